// ===== design/bb3_pkg.sv =====
// bb3_pkg: shared types, constants and arithmetic helpers of the 3x3 rgb box blur
// used by bb3_line_store, bb3_mean, box_blur_3x3_rgb and bb3_checker
package bb3_pkg;

   localparam int MaxWidthDefault = 1024;

   localparam int FrameWidthW  = 11;
   localparam int FrameHeightW = 16;
   localparam int CsrDataW     = 16;
   localparam int CsrIndexW    = 1;
   localparam int RowW         = 16;

   localparam logic [CsrIndexW-1:0] CsrFrameWidth  = 1'd0;
   localparam logic [CsrIndexW-1:0] CsrFrameHeight = 1'd1;

   localparam logic [FrameWidthW-1:0]  FrameWidthReset  = 11'd640;
   localparam logic [FrameHeightW-1:0] FrameHeightReset = 16'd480;

   // sum of up to nine 8-bit samples, then 2*sum+count, then times reciprocal
   localparam int SumW       = 12;
   localparam int CntW       = 4;
   localparam int DividendW  = 13;
   localparam int RecipW     = 18;
   localparam int RecipShift = 18;
   localparam int ProdW      = DividendW + RecipW;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   // row 0 is two rows up, column 0 is two columns left
   typedef pixel_type [2:0][2:0] window_type;

   typedef struct packed {
      pixel_type upper;
      pixel_type middle;
   } line_word_type;

   typedef struct packed {
      logic [1:0] row_lo;
      logic [1:0] col_lo;
   } mean_ctl_type;

   typedef enum logic [2:0] {
      StIdle,
      StRead,
      StSum,
      StMul,
      StOut
   } state_type;

   function automatic logic [CntW-1:0] window_count(input logic [1:0] row_lo,
                                                     input logic [1:0] col_lo);
      logic [1:0] rows;
      logic [1:0] cols;
      rows = 2'd3 - row_lo;
      cols = 2'd3 - col_lo;
      return CntW'(rows) * CntW'(cols);
   endfunction

   // ceil(2^18 / (2*count)), exact floor division for dividends below 2^13
   function automatic logic [RecipW-1:0] recip_of(input logic [CntW-1:0] cnt);
      logic [RecipW-1:0] m;
      unique case (cnt)
         4'd1:    m = 18'd131072;
         4'd2:    m = 18'd65536;
         4'd3:    m = 18'd43691;
         4'd4:    m = 18'd32768;
         4'd6:    m = 18'd21846;
         4'd9:    m = 18'd14564;
         default: m = '0;
      endcase
      return m;
   endfunction

endpackage

// ===== design/bb3_line_store.sv =====
// bb3_line_store: line memory holding the two previous rows, one word per column
// depends on bb3_pkg for the word type; one write and one registered read port
module bb3_line_store #(
   parameter int DEPTH = bb3_pkg::MaxWidthDefault
) (
   input  logic                          clock,
   input  logic                          rd_en,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   output bb3_pkg::line_word_type        rd_data,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  bb3_pkg::line_word_type        wr_data
);

   bb3_pkg::line_word_type line_mem [DEPTH];
   bb3_pkg::line_word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= line_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/bb3_mean.sv =====
// bb3_mean: two-stage rounded mean over the clipped part of the 3x3 window
// depends on bb3_pkg; stage one sums, stage two multiplies by a reciprocal
module bb3_mean (
   input  logic                  clock,
   input  bb3_pkg::window_type   window,
   input  bb3_pkg::mean_ctl_type ctl,
   output bb3_pkg::pixel_type    mean
);

   localparam int SumW      = bb3_pkg::SumW;
   localparam int CntW      = bb3_pkg::CntW;
   localparam int DividendW = bb3_pkg::DividendW;
   localparam int ProdW     = bb3_pkg::ProdW;

   logic [2:0][DividendW-1:0] dividend_in;
   logic [2:0][DividendW-1:0] dividend_ff;
   logic [CntW-1:0]           cnt_in;
   logic [CntW-1:0]           cnt_ff;
   logic [2:0][ProdW-1:0]     prod_ff;
   logic [2:0][7:0]           mean_ch;

   always_comb begin
      logic [2:0][SumW-1:0] sum;
      logic [2:0][7:0]      ch;
      sum    = '0;
      cnt_in = bb3_pkg::window_count(ctl.row_lo, ctl.col_lo);
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            ch = window[i][j];
            if (i >= int'(ctl.row_lo) && j >= int'(ctl.col_lo)) begin
               for (int k = 0; k < 3; k++) begin
                  sum[k] = sum[k] + SumW'(ch[k]);
               end
            end
         end
      end
      for (int k = 0; k < 3; k++) begin
         dividend_in[k] = {sum[k], 1'b0} + DividendW'(cnt_in);
      end
   end

   always_ff @(posedge clock) begin
      dividend_ff <= dividend_in;
      cnt_ff      <= cnt_in;
      for (int k = 0; k < 3; k++) begin
         prod_ff[k] <= ProdW'(dividend_ff[k]) * ProdW'(bb3_pkg::recip_of(cnt_ff));
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         mean_ch[k] = prod_ff[k][bb3_pkg::RecipShift +: 8];
      end
   end

   assign mean = mean_ch;

endmodule

// ===== design/box_blur_3x3_rgb.sv =====
// Streaming 3x3 box blur of an rgb frame in raster order. Each accepted pixel passes
// a line store read, then write-back and window shift, and each of the zero to four
// results it releases passes the sum stage, reciprocal multiply stage and output
// register; the output step waits while rsp_ready is low.
// The next pixel is taken once the last result of the current one sits in the output
// register. The line store is one memory of MAX_WIDTH words holding the two previous rows;
// it needs no clearing pass, as unwritten words never reach a result.
// depends on bb3_pkg, bb3_line_store and bb3_mean
module box_blur_3x3_rgb #(
   parameter int MAX_WIDTH = bb3_pkg::MaxWidthDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [bb3_pkg::CsrIndexW-1:0]  csr_index,
   input  logic [bb3_pkg::CsrDataW-1:0]   csr_wdata,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [7:0]                     req_red_in,
   input  logic [7:0]                     req_green_in,
   input  logic [7:0]                     req_blue_in,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [7:0]                     rsp_red_out,
   output logic [7:0]                     rsp_green_out,
   output logic [7:0]                     rsp_blue_out,
   output logic [bb3_pkg::RowW-1:0]       rsp_out_row,
   output logic [$clog2(MAX_WIDTH)-1:0]   rsp_out_col,
   output logic                           rsp_run_last,
   output logic                           rsp_frame_done
);

   localparam int ColW = $clog2(MAX_WIDTH);
   localparam int RowW = bb3_pkg::RowW;
   localparam int EW   = (ColW + 1 > bb3_pkg::FrameWidthW) ? ColW + 1 : bb3_pkg::FrameWidthW;

   typedef struct packed {
      bb3_pkg::pixel_type px;
      logic [RowW-1:0]    row;
      logic [ColW-1:0]    col;
      logic               row_ge1;
      logic               row_ge2;
      logic               col_ge1;
      logic               col_ge2;
      logic               last_row;
      logic               last_col;
      logic               row_sel;
      logic               col_sel;
   } job_type;

   bb3_pkg::state_type               state_ff, state_in;
   logic [bb3_pkg::FrameWidthW-1:0]  frame_width_ff;
   logic [bb3_pkg::FrameHeightW-1:0] frame_height_ff;
   logic [RowW-1:0]                  row_ff, row_in;
   logic [ColW-1:0]                  col_ff, col_in;
   job_type                          job_ff, job_in;
   bb3_pkg::window_type              window_ff, window_in;

   logic                             rsp_valid_ff;
   bb3_pkg::pixel_type               rsp_pixel_ff;
   logic [RowW-1:0]                  rsp_row_ff;
   logic [ColW-1:0]                  rsp_col_ff;
   logic                             rsp_last_ff;
   logic                             rsp_done_ff;

   logic [EW-1:0]                    width_ext;
   logic [EW-1:0]                    max_ext;
   logic [EW-1:0]                    eff_width;
   logic                             last_col_now;
   logic                             last_row_now;

   logic                             rd_en;
   logic                             wr_en;
   bb3_pkg::line_word_type           line_rd;
   bb3_pkg::line_word_type           line_wr;

   bb3_pkg::mean_ctl_type            mean_ctl;
   bb3_pkg::pixel_type               mean_px;

   logic                             out_free;
   logic                             load;
   logic                             more_col;
   logic                             more_row;
   logic                             has_result;

   // effective frame geometry
   assign width_ext = EW'(frame_width_ff);
   assign max_ext   = EW'(MAX_WIDTH);

   always_comb begin
      priority if (width_ext == '0) begin
         eff_width = EW'(1);
      end else if (width_ext > max_ext) begin
         eff_width = max_ext;
      end else begin
         eff_width = width_ext;
      end
   end

   assign last_col_now = EW'(col_ff) >= eff_width - EW'(1);
   assign last_row_now = (frame_height_ff == '0) ? 1'b1
                                                 : (row_ff >= frame_height_ff - 16'd1);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= bb3_pkg::FrameWidthReset;
         frame_height_ff <= bb3_pkg::FrameHeightReset;
      end else if (csr_wr_en) begin
         if (csr_index == bb3_pkg::CsrFrameWidth) begin
            frame_width_ff <= csr_wdata[bb3_pkg::FrameWidthW-1:0];
         end else if (csr_index == bb3_pkg::CsrFrameHeight) begin
            frame_height_ff <= csr_wdata[bb3_pkg::FrameHeightW-1:0];
         end
      end
   end

   bb3_line_store #(
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (col_ff),
      .rd_data (line_rd),
      .wr_en   (wr_en),
      .wr_addr (job_ff.col),
      .wr_data (line_wr)
   );

   assign line_wr.upper  = line_rd.middle;
   assign line_wr.middle = job_ff.px;

   // clipping of the window for the result being formed
   always_comb begin
      if (job_ff.row_sel) begin
         mean_ctl.row_lo = job_ff.row_ge1 ? 2'd1 : 2'd2;
      end else begin
         mean_ctl.row_lo = job_ff.row_ge2 ? 2'd0 : 2'd1;
      end
      if (job_ff.col_sel) begin
         mean_ctl.col_lo = job_ff.col_ge1 ? 2'd1 : 2'd2;
      end else begin
         mean_ctl.col_lo = job_ff.col_ge2 ? 2'd0 : 2'd1;
      end
   end

   bb3_mean u_mean (
      .clock  (clock),
      .window (window_ff),
      .ctl    (mean_ctl),
      .mean   (mean_px)
   );

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign more_col   = !job_ff.col_sel && job_ff.last_col;
   assign more_row   = !job_ff.row_sel && job_ff.last_row;
   assign has_result = (job_ff.row_ge1 || job_ff.last_row)
                    && (job_ff.col_ge1 || job_ff.last_col);

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      rd_en     = 1'b0;
      wr_en     = 1'b0;
      load      = 1'b0;
      row_in    = row_ff;
      col_in    = col_ff;
      job_in    = job_ff;
      window_in = window_ff;
      unique case (state_ff)
         bb3_pkg::StIdle: begin
            req_ready = 1'b1;
            if (req_valid) begin
               rd_en           = 1'b1;
               job_in.px       = '{red: req_red_in, green: req_green_in, blue: req_blue_in};
               job_in.row      = row_ff;
               job_in.col      = col_ff;
               job_in.row_ge1  = row_ff != '0;
               job_in.row_ge2  = row_ff >= RowW'(2);
               job_in.col_ge1  = col_ff != '0;
               job_in.col_ge2  = EW'(col_ff) >= EW'(2);
               job_in.last_row = last_row_now;
               job_in.last_col = last_col_now;
               if (last_col_now) begin
                  col_in = '0;
                  row_in = last_row_now ? '0 : row_ff + RowW'(1);
               end else begin
                  col_in = col_ff + ColW'(1);
               end
               state_in = bb3_pkg::StRead;
            end
         end
         bb3_pkg::StRead: begin
            wr_en = 1'b1;
            for (int i = 0; i < 3; i++) begin
               window_in[i][0] = window_ff[i][1];
               window_in[i][1] = window_ff[i][2];
            end
            window_in[0][2] = line_rd.upper;
            window_in[1][2] = line_rd.middle;
            window_in[2][2] = job_ff.px;
            job_in.row_sel  = !job_ff.row_ge1;
            job_in.col_sel  = !job_ff.col_ge1;
            state_in        = has_result ? bb3_pkg::StSum : bb3_pkg::StIdle;
         end
         bb3_pkg::StSum: begin
            state_in = bb3_pkg::StMul;
         end
         bb3_pkg::StMul: begin
            state_in = bb3_pkg::StOut;
         end
         bb3_pkg::StOut: begin
            if (out_free) begin
               load = 1'b1;
               priority if (more_col) begin
                  job_in.col_sel = 1'b1;
                  state_in       = bb3_pkg::StSum;
               end else if (more_row) begin
                  job_in.row_sel = 1'b1;
                  job_in.col_sel = !job_ff.col_ge1;
                  state_in       = bb3_pkg::StSum;
               end else begin
                  state_in = bb3_pkg::StIdle;
               end
            end
         end
         default: begin
            state_in = bb3_pkg::StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bb3_pkg::StIdle;
         row_ff       <= '0;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      job_ff    <= job_in;
      window_ff <= window_in;
      if (load) begin
         rsp_pixel_ff <= mean_px;
         rsp_row_ff   <= job_ff.row_sel ? job_ff.row : job_ff.row - RowW'(1);
         rsp_col_ff   <= job_ff.col_sel ? job_ff.col : job_ff.col - ColW'(1);
         rsp_last_ff  <= !(more_col || more_row);
         rsp_done_ff  <= job_ff.last_row && job_ff.last_col
                      && job_ff.row_sel && job_ff.col_sel;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_red_out    = rsp_pixel_ff.red;
   assign rsp_green_out  = rsp_pixel_ff.green;
   assign rsp_blue_out   = rsp_pixel_ff.blue;
   assign rsp_out_row    = rsp_row_ff;
   assign rsp_out_col    = rsp_col_ff;
   assign rsp_run_last   = rsp_last_ff;
   assign rsp_frame_done = rsp_done_ff;

endmodule

// ===== design/bb3_checker.sv =====
// bb3_checker: port-level assertions for box_blur_3x3_rgb, attached by bind
// depends on bb3_pkg for port widths
module bb3_checker #(
   parameter int MAX_WIDTH = bb3_pkg::MaxWidthDefault
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [7:0]                    rsp_red_out,
   input logic [7:0]                    rsp_green_out,
   input logic [7:0]                    rsp_blue_out,
   input logic [bb3_pkg::RowW-1:0]      rsp_out_row,
   input logic [$clog2(MAX_WIDTH)-1:0]  rsp_out_col,
   input logic                          rsp_run_last,
   input logic                          rsp_frame_done
);

   // stalled result transaction holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid
         && $stable(rsp_red_out) && $stable(rsp_green_out) && $stable(rsp_blue_out)
         && $stable(rsp_out_row) && $stable(rsp_out_col)
         && $stable(rsp_run_last) && $stable(rsp_frame_done))
      else $error("stalled result transaction changed");

   // frame end is the last result of its pixel
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> rsp_run_last)
      else $error("frame_done without run_last");

   // one pixel at a time: busy right after an accepted transaction
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after accepted transaction");

   // a new pixel is only taken once the previous pixel's results are all out
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !(rsp_valid && !rsp_run_last))
      else $error("pixel accepted with results still pending");

endmodule

bind box_blur_3x3_rgb bb3_checker #(
   .MAX_WIDTH (MAX_WIDTH)
) u_bb3_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_red_out    (rsp_red_out),
   .rsp_green_out  (rsp_green_out),
   .rsp_blue_out   (rsp_blue_out),
   .rsp_out_row    (rsp_out_row),
   .rsp_out_col    (rsp_out_col),
   .rsp_run_last   (rsp_run_last),
   .rsp_frame_done (rsp_frame_done)
);
